@@ rtl/core/lsu_pkg.sv @@
// Shared types, constants and helper functions for the logit and sigmoid unit.
package lsu_pkg;

   localparam int FRAC_BITS = 16;           // operand/result fraction bits
   localparam int RES_W     = 25;           // result width
   localparam int IW        = 36;           // internal datapath width
   localparam int IFB       = 32;           // internal fraction bits
   localparam int NS        = 28;           // steps per cell row
   localparam int SH_W      = 5;            // step shift width
   localparam int DW        = 40;           // logit accumulator width

   localparam logic [IW-1:0] ONE_I   = IW'(64'd1 << IFB);
   localparam logic [IW-1:0] TWO_I   = IW'(64'd1 << (IFB + 1));
   localparam logic [IW-1:0] LN2_I   = IW'(64'd2977044472);
   localparam logic [24:0]   INV_LN2 = 25'd24204406;   // floor(2^24 / ln2)

   localparam logic [24:0]   ONE_V   = 25'(1 << FRAC_BITS);    // probability 1.0
   localparam logic [24:0]   BIG_V   = 25'(24 << FRAC_BITS);   // e^-|x| flushes to zero

   localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
   localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

   // Mode bit values on the action field.
   localparam logic ACT_LOGIT   = 1'b0;
   localparam logic ACT_SIGMOID = 1'b1;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_SAT    = 2'd1,
      ST_DOMAIN = 2'd2
   } status_type;

   // One lane of the shift-and-add log/exp row.
   typedef struct packed {
      logic          exp_mode;
      logic [IW-1:0] x;
      logic [IW-1:0] z;
      logic [IW-1:0] m;
   } cell_type;

   // ln(1 + 2^-i) in Q.32, elaborated once per cell.
   function automatic logic [IW-1:0] ln_step(int i);
      real v;
      v = $ln(1.0 + 2.0 ** (-i)) * 4294967296.0;
      return IW'(longint'(v));
   endfunction

   // Position of the leading one in a 16-bit word.
   function automatic logic [3:0] msb16(logic [15:0] v);
      logic [3:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) r = 4'(i);
      end
      return r;
   endfunction

endpackage

@@ rtl/core/lsu_cell.sv @@
// One shift-and-add step, usable as a log step or an exp step.
module lsu_cell (
   input  logic                       clock,
   input  logic                       en,
   input  logic [lsu_pkg::SH_W-1:0]   sh,
   input  logic [lsu_pkg::IW-1:0]     lval,
   input  lsu_pkg::cell_type          din,
   output lsu_pkg::cell_type          dout
);

   lsu_pkg::cell_type c_ff;
   lsu_pkg::cell_type c_in;
   logic [lsu_pkg::IW-1:0] trial;

   assign trial = din.x + (din.x >> sh);

   always_comb begin
      c_in = din;
      if (din.exp_mode) begin
         // exp: peel ln(1+2^-i) off z, scale x
         if (din.z >= lval) begin
            c_in.z = din.z - lval;
            c_in.x = trial;
         end
      end else begin
         // log: grow x toward m, sum the logs taken
         if (trial <= din.m) begin
            c_in.x = trial;
            c_in.z = din.z + lval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) c_ff <= c_in;
   end

   assign dout = c_ff;

endmodule

@@ rtl/core/lsu_chain.sv @@
// Row of log/exp cells, one shift step per cell.
module lsu_chain (
   input  logic              clock,
   input  logic              en,
   input  lsu_pkg::cell_type din,
   output lsu_pkg::cell_type dout
);

   lsu_pkg::cell_type link [lsu_pkg::NS+1];

   assign link[0] = din;

   for (genvar i = 0; i < lsu_pkg::NS; i++) begin : g_cell
      lsu_cell u_cell (
         .clock (clock),
         .en    (en),
         .sh    (lsu_pkg::SH_W'(i + 1)),
         .lval  (lsu_pkg::ln_step(i + 1)),
         .din   (link[i]),
         .dout  (link[i+1])
      );
   end

   assign dout = link[lsu_pkg::NS];

endmodule

@@ rtl/core/logit_and_sigmoid_unit.sv @@
// Top level: logit and logistic sigmoid over a pipelined row of shift-and-add cells.
// Pipeline from an accepted req beat to its rsp beat: 3 front stages, three
//   28-cell rows, two joining stages and the output register.
// Throughput: one beat per cycle; the whole pipe advances unless the output register
//   holds a beat that is stalled.
// Reset (synchronous, active high) clears only the valid bits; payload is left as is.
module logit_and_sigmoid_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic signed [24:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [24:0]  rsp_result,
   output logic [1:0]          rsp_status
);

   // Per-beat sideband that rides alongside the cell rows.
   typedef struct packed {
      logic                                 valid;
      logic                                 action;
      logic                                 neg;
      logic                                 special;
      lsu_pkg::status_type                  status;
      logic signed [lsu_pkg::RES_W-1:0]     fixed;
      logic [5:0]                           n;
      logic                                 big;
      logic signed [5:0]                    dk;
      logic signed [lsu_pkg::DW-1:0]        d;
   } side_type;

   logic en;

   // Everything moves together; only a stalled full output register holds it.
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------------------------------------------------------------------
   // Stage 1: classify, magnitude, reciprocal product for range reduction
   // ---------------------------------------------------------------------------
   side_type    s1_side_ff, s1_side_in;
   logic [24:0] s1_a_ff, s1_a_in;
   logic [45:0] s1_prod_ff, s1_prod_in;
   logic [15:0] s1_p_ff, s1_q_ff, s1_p_in, s1_q_in;
   logic [3:0]  s1_kp_ff, s1_kq_ff, s1_kp_in, s1_kq_in;
   logic [24:0] vu;
   logic [16:0] q17;
   logic        domain, p_zero, p_one;

   assign vu = req_value;

   always_comb begin
      q17        = 17'(lsu_pkg::ONE_V) - vu[16:0];
      domain     = (req_value < 25'sd0) || (req_value > $signed(lsu_pkg::ONE_V));
      p_zero     = (vu == 25'd0);
      p_one      = (vu == lsu_pkg::ONE_V);
      s1_a_in    = req_value[24] ? (~vu + 25'd1) : vu;
      s1_prod_in = 46'(s1_a_in[20:0]) * 46'(lsu_pkg::INV_LN2);
      s1_p_in    = vu[15:0];
      s1_q_in    = q17[15:0];
      s1_kp_in   = lsu_pkg::msb16(vu[15:0]);
      s1_kq_in   = lsu_pkg::msb16(q17[15:0]);

      s1_side_in         = '0;
      s1_side_in.valid   = req_valid;
      s1_side_in.action  = req_action;
      s1_side_in.neg     = req_value[24];
      s1_side_in.big     = (s1_a_in >= lsu_pkg::BIG_V);
      s1_side_in.status  = lsu_pkg::ST_OK;
      s1_side_in.fixed   = '0;
      if (req_action == lsu_pkg::ACT_LOGIT) begin
         if (domain) begin
            s1_side_in.special = 1'b1;
            s1_side_in.status  = lsu_pkg::ST_DOMAIN;
         end else if (p_zero) begin
            s1_side_in.special = 1'b1;
            s1_side_in.status  = lsu_pkg::ST_SAT;
            s1_side_in.fixed   = lsu_pkg::RES_MIN;
         end else if (p_one) begin
            s1_side_in.special = 1'b1;
            s1_side_in.status  = lsu_pkg::ST_SAT;
            s1_side_in.fixed   = lsu_pkg::RES_MAX;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: mantissas for logit, estimated quotient and remainder for sigmoid
   // ---------------------------------------------------------------------------
   side_type                    s2_side_ff, s2_side_in;
   logic [lsu_pkg::IW-1:0]      s2_mp_ff, s2_mq_ff, s2_mp_in, s2_mq_in;
   logic [5:0]                  s2_n_ff, s2_n_in;
   logic [33:0]                 s2_r_ff, s2_r_in;
   logic [40:0]                 a32;

   always_comb begin
      a32      = {s1_a_ff, 16'b0};
      s2_n_in  = s1_prod_ff[45:40];
      s2_r_in  = 34'(a32 - 41'(s2_n_in) * 41'(lsu_pkg::LN2_I));
      s2_mp_in = lsu_pkg::IW'(s1_p_ff) << (6'(lsu_pkg::IFB) - 6'(s1_kp_ff));
      s2_mq_in = lsu_pkg::IW'(s1_q_ff) << (6'(lsu_pkg::IFB) - 6'(s1_kq_ff));
      s2_side_in    = s1_side_ff;
      s2_side_in.dk = $signed(6'(s1_kp_ff)) - $signed(6'(s1_kq_ff));
   end

   // ---------------------------------------------------------------------------
   // Stage 3: finish range reduction, load the first cell row (two lanes)
   // ---------------------------------------------------------------------------
   side_type               s3_side_ff, s3_side_in;
   lsu_pkg::cell_type      a0_ff, a1_ff, a0_in, a1_in;
   logic [33:0]            r_fix;

   always_comb begin
      s3_side_in = s2_side_ff;
      r_fix      = s2_r_ff;
      if (s2_r_ff >= 34'(lsu_pkg::LN2_I)) begin
         r_fix        = s2_r_ff - 34'(lsu_pkg::LN2_I);
         s3_side_in.n = s2_n_ff + 6'd1;
      end else begin
         s3_side_in.n = s2_n_ff;
      end

      // sigmoid: e^(ln2 - r) then halve later; logit: ln of both mantissas
      a0_in = '0;
      a0_in.x = lsu_pkg::ONE_I;
      if (s2_side_ff.action == lsu_pkg::ACT_SIGMOID) begin
         a0_in.exp_mode = 1'b1;
         a0_in.z        = lsu_pkg::LN2_I - lsu_pkg::IW'(r_fix);
      end else begin
         a0_in.m        = s2_mp_ff;
      end
      a1_in   = '0;
      a1_in.x = lsu_pkg::ONE_I;
      a1_in.m = s2_mq_ff;
   end

   lsu_pkg::cell_type oa0, oa1, ob, oc;

   lsu_chain u_row_a0 (.clock(clock), .en(en), .din(a0_ff), .dout(oa0));
   lsu_chain u_row_a1 (.clock(clock), .en(en), .din(a1_ff), .dout(oa1));

   side_type side_a_ff [lsu_pkg::NS];
   side_type side_b_ff [lsu_pkg::NS];
   side_type side_c_ff [lsu_pkg::NS];

   // ---------------------------------------------------------------------------
   // Stage 4: logit difference; sigmoid 1 + e^-|x| into the log row
   // ---------------------------------------------------------------------------
   side_type               s4_side_ff, s4_side_in;
   lsu_pkg::cell_type      b_ff, b_in;
   side_type               sa;
   logic [lsu_pkg::IW-1:0] e_val;
   logic signed [lsu_pkg::DW-1:0] zp_s, zq_s, dk_s, ln2_s;

   assign sa = side_a_ff[lsu_pkg::NS-1];

   always_comb begin
      zp_s  = $signed(lsu_pkg::DW'(oa0.z));
      zq_s  = $signed(lsu_pkg::DW'(oa1.z));
      dk_s  = lsu_pkg::DW'(sa.dk);
      ln2_s = $signed(lsu_pkg::DW'(lsu_pkg::LN2_I));
      s4_side_in   = sa;
      s4_side_in.d = zp_s - zq_s + dk_s * ln2_s;

      e_val = oa0.x >> (sa.n + 6'd1);
      if (sa.big) e_val = '0;
      b_in   = '0;
      b_in.x = lsu_pkg::ONE_I;
      b_in.m = lsu_pkg::ONE_I + e_val;
   end

   lsu_chain u_row_b (.clock(clock), .en(en), .din(b_ff), .dout(ob));

   // ---------------------------------------------------------------------------
   // Stage 5: sigmoid(|x|) = e^-L = e^(ln2 - L) / 2, into the exp row
   // ---------------------------------------------------------------------------
   side_type          s5_side_ff;
   lsu_pkg::cell_type c_ff, c_in;

   always_comb begin
      c_in          = '0;
      c_in.exp_mode = 1'b1;
      c_in.x        = lsu_pkg::ONE_I;
      c_in.z        = (ob.z >= lsu_pkg::LN2_I) ? '0 : (lsu_pkg::LN2_I - ob.z);
   end

   lsu_chain u_row_c (.clock(clock), .en(en), .din(c_ff), .dout(oc));

   // ---------------------------------------------------------------------------
   // Output stage: rounding, reflection for negative x, clipping
   // ---------------------------------------------------------------------------
   side_type                         out_side;
   logic                             rsp_valid_ff;
   logic signed [lsu_pkg::RES_W-1:0] rsp_result_ff, rsp_result_in;
   lsu_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [lsu_pkg::IW-1:0]           sval, srnd;
   logic signed [lsu_pkg::DW-1:0]    lrnd;

   assign out_side = side_c_ff[lsu_pkg::NS-1];

   always_comb begin
      // x holds 2*sigmoid(|x|) in Q4.32; 1 - s for negative x
      if (out_side.neg) begin
         sval = (oc.x > lsu_pkg::TWO_I) ? '0 : (lsu_pkg::TWO_I - oc.x);
      end else begin
         sval = oc.x;
      end
      srnd = (sval + lsu_pkg::IW'(1 << 16)) >> 17;
      lrnd = (out_side.d + lsu_pkg::DW'(1 << 15)) >>> 16;

      rsp_status_in = lsu_pkg::ST_OK;
      if (out_side.special) begin
         rsp_result_in = out_side.fixed;
         rsp_status_in = out_side.status;
      end else if (out_side.action == lsu_pkg::ACT_SIGMOID) begin
         if (srnd > lsu_pkg::IW'((1 << lsu_pkg::FRAC_BITS) - 1)) begin
            rsp_result_in = lsu_pkg::RES_W'((1 << lsu_pkg::FRAC_BITS) - 1);
         end else begin
            rsp_result_in = lsu_pkg::RES_W'(srnd);
         end
      end else if (lrnd > lsu_pkg::DW'(lsu_pkg::RES_MAX)) begin
         rsp_result_in = lsu_pkg::RES_MAX;
         rsp_status_in = lsu_pkg::ST_SAT;
      end else if (lrnd < lsu_pkg::DW'(lsu_pkg::RES_MIN)) begin
         rsp_result_in = lsu_pkg::RES_MIN;
         rsp_status_in = lsu_pkg::ST_SAT;
      end else begin
         rsp_result_in = lsu_pkg::RES_W'(lrnd);
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.valid <= 1'b0;
         s2_side_ff.valid <= 1'b0;
         s3_side_ff.valid <= 1'b0;
         s4_side_ff.valid <= 1'b0;
         s5_side_ff.valid <= 1'b0;
         for (int i = 0; i < lsu_pkg::NS; i++) begin
            side_a_ff[i].valid <= 1'b0;
            side_b_ff[i].valid <= 1'b0;
            side_c_ff[i].valid <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_side_ff <= s1_side_in;
         s1_a_ff    <= s1_a_in;
         s1_prod_ff <= s1_prod_in;
         s1_p_ff    <= s1_p_in;
         s1_q_ff    <= s1_q_in;
         s1_kp_ff   <= s1_kp_in;
         s1_kq_ff   <= s1_kq_in;
         s2_side_ff <= s2_side_in;
         s2_mp_ff   <= s2_mp_in;
         s2_mq_ff   <= s2_mq_in;
         s2_n_ff    <= s2_n_in;
         s2_r_ff    <= s2_r_in;
         s3_side_ff <= s3_side_in;
         a0_ff      <= a0_in;
         a1_ff      <= a1_in;
         s4_side_ff <= s4_side_in;
         b_ff       <= b_in;
         s5_side_ff <= side_b_ff[lsu_pkg::NS-1];
         c_ff       <= c_in;
         side_a_ff[0] <= s3_side_ff;
         side_b_ff[0] <= s4_side_ff;
         side_c_ff[0] <= s5_side_ff;
         for (int i = 1; i < lsu_pkg::NS; i++) begin
            side_a_ff[i] <= side_a_ff[i-1];
            side_b_ff[i] <= side_b_ff[i-1];
            side_c_ff[i] <= side_c_ff[i-1];
         end
         rsp_valid_ff  <= out_side.valid;
         rsp_result_ff <= rsp_result_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_domain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lsu_pkg::ST_DOMAIN |-> rsp_result == '0)
      else $error("domain beat with nonzero result");

   a_sigmoid_range: assert property (@(posedge clock) disable iff (reset)
      en && out_side.valid && out_side.action == lsu_pkg::ACT_SIGMOID |=>
         rsp_status == lsu_pkg::ST_OK && rsp_result[24:16] == '0)
      else $error("sigmoid beat out of range or flagged");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output is blocked");
`endif

endmodule
